// File: rtl/core/trde_pkg.sv
// Shared types and codes of the threshold rule DNF evaluator.
package trde_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_RULE = 2'd0;
  localparam logic [1:0] KIND_FEAT = 2'd1;
  localparam logic [1:0] KIND_EVAL = 2'd2;

  // Rule counter and group counter width (rule_count tops out at 31)
  localparam int CNT_W = 5;

  // Comparison codes; codes 6 and 7 compare as false
  typedef enum logic [2:0] {
    OP_EQ = 3'd0,
    OP_NE = 3'd1,
    OP_LT = 3'd2,
    OP_LE = 3'd3,
    OP_GT = 3'd4,
    OP_GE = 3'd5
  } op_e;

  // One rule table entry, 44 bits
  typedef struct packed {
    logic [3:0]         feature;
    logic [2:0]         op;
    logic               negate;
    logic [3:0]         group;
    logic signed [31:0] threshold;
  } rule_t;

  // Controller to datapath
  typedef struct packed {
    logic             wr_rule;
    logic             wr_feat;
    logic             start;
    logic             issue;
    logic             issue_last;
    logic             load_out;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
  } sts_t;

endpackage

// File: rtl/core/trde_ctrl.sv
// Controller: handshakes, rule count register, walk sequencing, output beat.
module trde_ctrl #(
  parameter int MAX_RULES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [trde_pkg::CNT_W-1:0]  cfg_data_i,
  input  trde_pkg::sts_t              sts_i,
  output trde_pkg::cmd_t              cmd_o
);
  import trde_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [8:0] RuleDepth = 9'(MAX_RULES);

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] rule_count_q;
  logic             out_valid_q, out_valid_d;
  logic [8:0]       limit_w;
  logic [CNT_W-1:0] limit;
  logic             in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Rules in use, clipped to the table depth
  assign limit_w = ({4'd0, rule_count_q} > RuleDepth) ? RuleDepth : {4'd0, rule_count_q};
  assign limit   = limit_w[CNT_W-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (kind_i)
            KIND_RULE: cmd_o.wr_rule = 1'b1;
            KIND_FEAT: cmd_o.wr_feat = 1'b1;
            KIND_EVAL: begin
              cmd_o.start = 1'b1;
              idx_d       = '0;
              state_d     = (limit == '0) ? S_DONE : S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (sts_i.done) begin
          state_d = S_DONE;
        end else if (idx_q < limit) begin
          cmd_o.issue      = 1'b1;
          cmd_o.issue_last = (idx_q == limit - CNT_W'(1));
          idx_d            = idx_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        // Move the result into the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      rule_count_q <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        rule_count_q <= cfg_data_i;
      end
    end
  end

endmodule

// File: rtl/core/trde_dpath.sv
// Datapath: rule and feature memories, compare pipeline, group walk, result.
module trde_dpath #(
  parameter int MAX_RULES    = 16,
  parameter int MAX_FEATURES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trde_pkg::cmd_t     cmd_i,
  output trde_pkg::sts_t     sts_o,
  input  logic [3:0]         slot_i,
  input  logic [3:0]         rule_feature_i,
  input  logic [2:0]         rule_op_i,
  input  logic               rule_negate_i,
  input  logic [3:0]         rule_group_i,
  input  logic signed [31:0] operand_value_i,
  output logic               match_o
);
  import trde_pkg::*;

  localparam int RIW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int FIW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam logic [8:0] RuleDepth = 9'(MAX_RULES);
  localparam logic [8:0] FeatDepth = 9'(MAX_FEATURES);

  rule_t              rule_mem [MAX_RULES];
  logic signed [31:0] feat_mem [MAX_FEATURES];
  logic [MAX_FEATURES-1:0] fvalid_q;

  rule_t              wr_entry;
  logic               wr_rule_ok, wr_feat_ok;
  logic [RIW-1:0]     rule_wr_addr, rule_rd_addr;
  logic [FIW-1:0]     feat_wr_addr, feat_rd_addr;
  logic               fidx_ok;

  rule_t              rule1_q, rule2_q;
  logic               v1_q, last1_q, v2_q, last2_q;
  logic signed [31:0] feat_rd_q;
  logic               feat_ok_q;

  logic [CNT_W-1:0]   gctr_q;
  logic               last_q, res_q, match_q;

  logic signed [31:0] value;
  logic               cmp, cmp_ok;
  logic [CNT_W-1:0]   grp_x;
  logic               early, skip, step, done, result;

  // Write decode with slot range checks
  assign wr_entry     = '{feature: rule_feature_i, op: rule_op_i, negate: rule_negate_i,
                          group: rule_group_i, threshold: operand_value_i};
  assign wr_rule_ok   = cmd_i.wr_rule && ({5'd0, slot_i} < RuleDepth);
  assign wr_feat_ok   = cmd_i.wr_feat && ({5'd0, slot_i} < FeatDepth);
  assign rule_wr_addr = RIW'(slot_i);
  assign feat_wr_addr = FIW'(slot_i);
  assign rule_rd_addr = RIW'(cmd_i.idx);
  assign feat_rd_addr = FIW'(rule1_q.feature);
  assign fidx_ok      = ({5'd0, rule1_q.feature} < FeatDepth);

  // Rule memory, registered read (stage 1)
  always_ff @(posedge clk_i) begin
    if (wr_rule_ok) begin
      rule_mem[rule_wr_addr] <= wr_entry;
    end
    rule1_q <= rule_mem[rule_rd_addr];
  end

  // Feature memory, registered read (stage 2)
  always_ff @(posedge clk_i) begin
    if (wr_feat_ok) begin
      feat_mem[feat_wr_addr] <= operand_value_i;
    end
    feat_rd_q <= feat_mem[feat_rd_addr];
    rule2_q   <= rule1_q;
  end

  // Compare stage
  assign value = feat_ok_q ? feat_rd_q : 32'sd0;

  always_comb begin
    case (rule2_q.op)
      OP_EQ:   cmp = (value == rule2_q.threshold);
      OP_NE:   cmp = (value != rule2_q.threshold);
      OP_LT:   cmp = (value <  rule2_q.threshold);
      OP_LE:   cmp = (value <= rule2_q.threshold);
      OP_GT:   cmp = (value >  rule2_q.threshold);
      OP_GE:   cmp = (value >= rule2_q.threshold);
      default: cmp = 1'b0;
    endcase
  end

  assign cmp_ok = cmp ^ rule2_q.negate;
  assign grp_x  = {1'b0, rule2_q.group};
  // A finished group followed by a later one ends the walk with a match
  assign early  = v2_q && last_q && (grp_x > gctr_q);
  // Rest of a failed group
  assign skip   = (grp_x < gctr_q);
  assign step   = v2_q && !early && !skip;
  assign done   = early || (v2_q && last2_q);
  assign result = early ? 1'b1 : (skip ? last_q : cmp_ok);

  assign sts_o.done = done;
  assign match_o    = match_q;

  // Pipeline control, walk state and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q  <= '0;
      feat_ok_q <= 1'b0;
      v1_q      <= 1'b0;
      last1_q   <= 1'b0;
      v2_q      <= 1'b0;
      last2_q   <= 1'b0;
      gctr_q    <= '0;
      last_q    <= 1'b0;
      res_q     <= 1'b0;
      match_q   <= 1'b0;
    end else begin
      if (wr_feat_ok) begin
        fvalid_q[feat_wr_addr] <= 1'b1;
      end
      feat_ok_q <= fidx_ok && fvalid_q[feat_rd_addr];

      // Drop beats still in flight once the walk has ended
      if (done) begin
        v1_q <= 1'b0;
        v2_q <= 1'b0;
      end else begin
        v1_q <= cmd_i.issue;
        v2_q <= v1_q;
      end
      last1_q <= cmd_i.issue_last;
      last2_q <= last1_q;

      if (cmd_i.start) begin
        gctr_q <= '0;
        last_q <= 1'b0;
        res_q  <= 1'b0;
      end else begin
        if (step) begin
          last_q <= cmp_ok;
          if (!cmp_ok) begin
            gctr_q <= gctr_q + CNT_W'(1);
          end
        end
        if (done) begin
          res_q <= result;
        end
      end

      if (cmd_i.load_out) begin
        match_q <= res_q;
      end
    end
  end

endmodule

// File: rtl/core/threshold_rule_dnf_evaluator.sv
// Top level of the threshold rule DNF evaluator.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | kind, slot, rule fields, operand_value
//  out     | output    | out_valid_o / out_stall_i| match
//  cfg     | input     | cfg_valid_i / cfg_ready_o| rule_count
//
// Rule and feature writes are taken without a stall. An evaluation walks the rules up to
// the one that ends the walk (at most rule_count clipped to MAX_RULES) and registers its
// result beat; with no rules in use it goes straight to the result.
// One rule per cycle passes the rule memory read, the feature memory read and the compare.
// in_stall_o stays high from an evaluate beat until its result enters the output register,
// which holds under out_stall_i. Reset clears the feature store, rule_count and control state, not the rules.
module threshold_rule_dnf_evaluator #(
  parameter int MAX_RULES    = 16,
  parameter int MAX_FEATURES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [3:0]                  slot_i,
  input  logic [3:0]                  rule_feature_i,
  input  logic [2:0]                  rule_op_i,
  input  logic                        rule_negate_i,
  input  logic [3:0]                  rule_group_i,
  input  logic signed [31:0]          operand_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        match_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [trde_pkg::CNT_W-1:0]  cfg_data_i
);
  import trde_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Control
  trde_ctrl #(
    .MAX_RULES(MAX_RULES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and compare
  trde_dpath #(
    .MAX_RULES   (MAX_RULES),
    .MAX_FEATURES(MAX_FEATURES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .slot_i         (slot_i),
    .rule_feature_i (rule_feature_i),
    .rule_op_i      (rule_op_i),
    .rule_negate_i  (rule_negate_i),
    .rule_group_i   (rule_group_i),
    .operand_value_i(operand_value_i),
    .match_o        (match_o)
  );

endmodule

// File: rtl/core/trde_checker.sv
// Port-level checks of the threshold rule DNF evaluator, bound to the top level.
module trde_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_i,
  input logic [1:0]                 kind_i,
  input logic                       out_valid_i,
  input logic                       out_stall_i,
  input logic                       match_i
);
  import trde_pkg::*;

  // An evaluate beat keeps the input side stalled until its result is out
  a_eval_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i && (kind_i == KIND_EVAL) |=> in_stall_i)
    else $error("input not stalled after evaluate beat");

  // Writes and unused kinds do not stall the input
  a_write_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i && (kind_i != KIND_EVAL) |=> !in_stall_i)
    else $error("input stalled after write beat");

  // A new result only appears at the end of an evaluation
  a_result_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_stall_i))
    else $error("result beat without evaluation");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(match_i))
    else $error("stalled result beat changed");

endmodule

bind threshold_rule_dnf_evaluator trde_checker u_trde_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .kind_i     (kind_i),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .match_i    (match_o)
);

// File: dv/threshold_rule_dnf_evaluator_checker.sv
// Scoreboard for the threshold rule DNF evaluator: tracks writes, predicts match beats.
`timescale 1ns / 1ps
module threshold_rule_dnf_evaluator_checker #(
  parameter int MAX_RULES    = 16,
  parameter int MAX_FEATURES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [1:0]                 kind_i,
  input  logic [3:0]                 slot_i,
  input  logic [3:0]                 rule_feature_i,
  input  logic [2:0]                 rule_op_i,
  input  logic                       rule_negate_i,
  input  logic [3:0]                 rule_group_i,
  input  logic signed [31:0]         operand_value_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       match_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [trde_pkg::CNT_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  // Shadow copy of the block state
  trde_pkg::rule_t            rule_mem [MAX_RULES];
  logic signed [31:0]         feat_mem [MAX_FEATURES];
  logic [trde_pkg::CNT_W-1:0] rule_count_q;

  // Expected match bits, oldest first
  bit match_q [$];

  // One rule against the current feature store, inversion applied
  function automatic bit rule_holds(trde_pkg::rule_t r);
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
    bit                 ok;
    lhs = (r.feature < MAX_FEATURES) ? feat_mem[r.feature] : '0;
    rhs = r.threshold;
    case (r.op)
      trde_pkg::OP_EQ: ok = (lhs == rhs);
      trde_pkg::OP_NE: ok = (lhs != rhs);
      trde_pkg::OP_LT: ok = (lhs < rhs);
      trde_pkg::OP_LE: ok = (lhs <= rhs);
      trde_pkg::OP_GT: ok = (lhs > rhs);
      trde_pkg::OP_GE: ok = (lhs >= rhs);
      default:         ok = 1'b0;
    endcase
    return ok ^ r.negate;
  endfunction

  // Walk the active rules: skip the rest of a failed group, stop once a group held
  function automatic bit dnf_match();
    int              lim;
    int              grp_ctr;
    bit              last;
    trde_pkg::rule_t r;
    lim     = (rule_count_q > MAX_RULES) ? MAX_RULES : int'(rule_count_q);
    grp_ctr = 0;
    last    = 1'b0;
    for (int i = 0; i < lim; i++) begin
      r = rule_mem[i];
      if (last && int'(r.group) > grp_ctr) return 1'b1;
      if (int'(r.group) < grp_ctr) continue;
      last = rule_holds(r);
      if (!last) grp_ctr++;
    end
    return last;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 40) $display("ERROR at %0t: %s", $time, msg);
    fail_count_o++;
  endtask

  // Sample all three channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_FEATURES; i++) feat_mem[i] = '0;
      rule_count_q = '0;
      match_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) rule_count_q = cfg_data_i;

      // result beat against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (match_q.size() == 0) begin
          report_mismatch($sformatf("match beat %0b with no evaluation pending", match_i));
        end else begin
          want = match_q.pop_front();
          if (match_i !== want)
            report_mismatch($sformatf("match got %0b, expected %0b", match_i, want));
        end
      end

      // input beat updates the shadow state or queues a prediction
      if (in_valid_i && !in_stall_i) begin
        case (kind_i)
          trde_pkg::KIND_RULE: begin
            if (slot_i < MAX_RULES) begin
              rule_mem[slot_i].feature   = rule_feature_i;
              rule_mem[slot_i].op        = rule_op_i;
              rule_mem[slot_i].negate    = rule_negate_i;
              rule_mem[slot_i].group     = rule_group_i;
              rule_mem[slot_i].threshold = operand_value_i;
            end
          end
          trde_pkg::KIND_FEAT: begin
            if (slot_i < MAX_FEATURES) feat_mem[slot_i] = operand_value_i;
          end
          trde_pkg::KIND_EVAL: match_q = {match_q, dnf_match()};
          default: ;
        endcase
      end

      pending_o <= match_q.size();
    end
  end

endmodule

// File: dv/threshold_rule_dnf_evaluator_tb.sv
// Testbench top for the threshold rule DNF evaluator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module threshold_rule_dnf_evaluator_tb;
  import trde_pkg::*;

  localparam int MAX_RULES    = 16;
  localparam int MAX_FEATURES = 16;
  localparam int N_ITEMS      = 1100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [1:0]         kind          = '0;
  logic [3:0]         slot          = '0;
  logic [3:0]         rule_feature  = '0;
  logic [2:0]         rule_op       = '0;
  logic               rule_negate   = 1'b0;
  logic [3:0]         rule_group    = '0;
  logic signed [31:0] operand_value = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic               match;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data      = '0;

  int fail_cnt;
  int pend;

  // Traffic control: calm shared by the sender and the receiver, hold state of the receiver
  logic calm      = 1'b0;
  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cycles    = 0;

  // Stimulus bookkeeping
  int          beats_sent = 0;
  int          active_n   = 0;
  logic [3:0]  rule_feat_sh [MAX_RULES];
  logic [3:0]  rule_grp_sh  [MAX_RULES];
  logic [31:0] rule_thr_sh  [MAX_RULES];
  int          rc_plan [9]  = '{1, 16, 2, 31, 5, 17, 0, 8, 12};

  threshold_rule_dnf_evaluator #(
    .MAX_RULES   (MAX_RULES),
    .MAX_FEATURES(MAX_FEATURES)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .slot_i         (slot),
    .rule_feature_i (rule_feature),
    .rule_op_i      (rule_op),
    .rule_negate_i  (rule_negate),
    .rule_group_i   (rule_group),
    .operand_value_i(operand_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .match_o        (match),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  threshold_rule_dnf_evaluator_checker #(
    .MAX_RULES   (MAX_RULES),
    .MAX_FEATURES(MAX_FEATURES)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .kind_i         (kind),
    .slot_i         (slot),
    .rule_feature_i (rule_feature),
    .rule_op_i      (rule_op),
    .rule_negate_i  (rule_negate),
    .rule_group_i   (rule_group),
    .operand_value_i(operand_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .match_i        (match),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_cnt),
    .pending_o      (pend)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: one long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 15);
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic [1:0] k, input logic [3:0] s, input logic [3:0] f,
                           input logic [2:0] op, input logic neg, input logic [3:0] g,
                           input logic [31:0] val);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    kind          <= k;
    slot          <= s;
    rule_feature  <= f;
    rule_op       <= op;
    rule_negate   <= neg;
    rule_group    <= g;
    operand_value <= val;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (k == KIND_RULE) begin
      rule_feat_sh[s] = f;
      rule_grp_sh[s]  = g;
      rule_thr_sh[s]  = val;
    end
    if (k != KIND_NONE) beats_sent++;
  endtask

  task automatic evaluate();
    send_beat(KIND_EVAL, 4'($urandom), 4'($urandom), 3'($urandom), 1'($urandom),
              4'($urandom), $urandom);
  endtask

  // Q16.16 values: extremes, values near zero, whole numbers, full random
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h1;
      5, 6:    return ($urandom_range(0, 8) - 4) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? OP_BAD_HI : OP_BAD_LO;
    return 3'($urandom_range(0, 5));
  endfunction

  // Register writes only when the block is idle
  task automatic set_rule_count(input logic [CNT_W-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (pend != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_n = (v > MAX_RULES) ? MAX_RULES : int'(v);
  endtask

  // Write the active rules with groups rising from zero in steps of at most one
  task automatic load_rule_set();
    logic [3:0] g;
    g = '0;
    for (int i = 0; i < active_n; i++) begin
      if (i > 0 && $urandom_range(0, 2) == 0) g++;
      send_beat(KIND_RULE, 4'(i), 4'($urandom), pick_op(), 1'($urandom), g, pick_q16());
    end
  endtask

  // Feature write, often right at or next to a rule threshold
  task automatic nudge_feature();
    int i;
    if (active_n > 0 && $urandom_range(0, 1)) begin
      i = $urandom_range(0, active_n - 1);
      send_beat(KIND_FEAT, rule_feat_sh[i], 4'($urandom), 3'($urandom), 1'($urandom),
                4'($urandom), rule_thr_sh[i] + $urandom_range(0, 2) - 1);
    end else begin
      send_beat(KIND_FEAT, 4'($urandom), 4'($urandom), 3'($urandom), 1'($urandom),
                4'($urandom), pick_q16());
    end
  endtask

  // Mostly well-formed rule sets with evaluations, the rest raw noise
  task automatic run_block(input bit fresh);
    int i;
    if ($urandom_range(0, 99) < 70) begin
      if (fresh || $urandom_range(0, 99) < 35) begin
        load_rule_set();
      end else if (active_n > 0) begin
        repeat ($urandom_range(1, 2)) begin
          i = $urandom_range(0, active_n - 1);
          send_beat(KIND_RULE, 4'(i), 4'($urandom), pick_op(), 1'($urandom), rule_grp_sh[i],
                    pick_q16());
        end
      end
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(1, 3)) nudge_feature();
        evaluate();
      end
    end else begin
      repeat ($urandom_range(1, 4))
        send_beat(2'($urandom), 4'($urandom), 4'($urandom), 3'($urandom), 1'($urandom),
                  4'($urandom), $urandom);
      evaluate();
    end
  endtask

  initial begin
    int               phase;
    logic [CNT_W-1:0] rc;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty rule set, ignored kind, extreme features
    evaluate();
    send_beat(KIND_NONE, 4'($urandom), 4'($urandom), 3'($urandom), 1'($urandom),
              4'($urandom), $urandom);
    send_beat(KIND_FEAT, 4'd0, 4'd0, OP_EQ, 1'b0, 4'd0, 32'h7FFF_FFFF);
    send_beat(KIND_FEAT, 4'd1, 4'd0, OP_EQ, 1'b0, 4'd0, 32'h8000_0000);
    send_beat(KIND_FEAT, 4'd15, 4'd0, OP_EQ, 1'b0, 4'd0, 32'hFFFF_0000);

    // Group 0 fails on an unknown op, group 1 fails on negated eq,
    // group 2 holds, group 3 start ends the walk with a match
    send_beat(KIND_RULE, 4'd0, 4'd0, OP_GE, 1'b0, 4'd0, 32'h7FFF_FFFF);
    send_beat(KIND_RULE, 4'd1, 4'd1, OP_LE, 1'b0, 4'd0, 32'h8000_0000);
    send_beat(KIND_RULE, 4'd2, 4'd15, OP_BAD_LO, 1'b0, 4'd0, 32'h0);
    send_beat(KIND_RULE, 4'd3, 4'd2, OP_EQ, 1'b1, 4'd1, 32'h0);
    send_beat(KIND_RULE, 4'd4, 4'd0, OP_NE, 1'b0, 4'd2, 32'h0);
    send_beat(KIND_RULE, 4'd5, 4'd1, OP_LT, 1'b0, 4'd2, 32'h0);
    send_beat(KIND_RULE, 4'd6, 4'd15, OP_BAD_HI, 1'b1, 4'd2, 32'hFFFF_FFFF);
    send_beat(KIND_RULE, 4'd7, 4'd15, OP_GT, 1'b0, 4'd3, 32'hFFFE_0000);
    for (int i = 8; i < MAX_RULES; i++)
      send_beat(KIND_RULE, 4'(i), 4'(i), 3'((i - 8) % 6), 1'(i % 2), 4'(3 + (i - 8) / 2),
                pick_q16());

    set_rule_count(5'd16);
    evaluate();
    set_rule_count(5'd31);
    evaluate();
    set_rule_count(5'd3);
    evaluate();

    // Random phases, each with its own rule count
    phase = 0;
    while (beats_sent < N_ITEMS) begin
      rc = (phase < 9) ? CNT_W'(rc_plan[phase]) : CNT_W'($urandom_range(0, 31));
      calm <= (phase == 2);
      if (phase == 4) hold_go <= 1'b1;
      set_rule_count(rc);
      run_block(1'b1);
      repeat ($urandom_range(3, 7)) run_block(1'b0);
      phase++;
    end

    // Drain
    in_valid <= 1'b0;
    do @(posedge clk); while (pend != 0);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/trde_pkg.sv
rtl/core/trde_ctrl.sv
rtl/core/trde_dpath.sv
rtl/core/threshold_rule_dnf_evaluator.sv
rtl/core/trde_checker.sv
dv/threshold_rule_dnf_evaluator_checker.sv
dv/threshold_rule_dnf_evaluator_tb.sv
